>>> hw/rtl/byte_queue_with_peek_and_search_top_defines.svh
// Assertion macros for the byte queue checker.
`ifndef BYTE_QUEUE_WITH_PEEK_AND_SEARCH_TOP_DEFINES_SVH
`define BYTE_QUEUE_WITH_PEEK_AND_SEARCH_TOP_DEFINES_SVH

// Clocked on i_clk, quiet while i_rst_n is low.
`define BQPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked on i_clk, also checked across reset.
`define BQPS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/bqps_pkg.sv
// Package for the byte queue: sizes, op codes, state type, pointer wrap.
package bqps_pkg;

    localparam int CAPACITY = 4096;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LVL_W    = $clog2(CAPACITY + 1);

    // Port field widths
    localparam int KIND_W  = 3;
    localparam int DATA_W  = 8;
    localparam int POS_W   = 12;
    localparam int COUNT_W = 13;
    localparam int FILL_W  = 13;

    // Common width for level compares
    localparam int CMP_W = (LVL_W > COUNT_W) ? LVL_W : COUNT_W;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [LVL_W-1:0] t_level;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH    = 3'd0,
        KIND_POP     = 3'd1,
        KIND_DISCARD = 3'd2,
        KIND_READ    = 3'd3,
        KIND_FIND    = 3'd4
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    // base + delta modulo CAPACITY; delta never exceeds CAPACITY
    function automatic t_ptr wrap_add(input t_ptr base, input t_level delta);
        logic [LVL_W:0] sum;
        sum = (LVL_W+1)'(base) + (LVL_W+1)'(delta);
        if (sum >= (LVL_W+1)'(CAPACITY)) begin
            sum = sum - (LVL_W+1)'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

>>> hw/rtl/byte_queue_with_peek_and_search_top.sv
// Top level of the byte queue with peek and search.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | into      | i_valid / o_ready   | i_kind, i_data_in, i_position, i_count
//  out     | out of    | o_valid / i_ready   | o_data_out, o_ok, o_found_position,
//          |           |                     | o_amount_removed, o_fill_level
//
// Push, pop, discard and read take one beat per cycle while no find runs and the
// output is not stalled; each result passes through the pending stage (RAM read)
// and then the output register. Find scans the held bytes through the single RAM
// read port, one byte a cycle once the pending stage has drained, and stops early
// on a match; no input is taken meanwhile. Reset is synchronous and clears the
// state, pointers, fill level and valid flags; the byte store needs no clearing
// since only pushed entries are ever read. A stalled output holds the result register;
// the next beat is still taken while the pending stage is empty or can move on in the same cycle.
module byte_queue_with_peek_and_search_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bqps_pkg::KIND_W-1:0]   i_kind,
    input  logic [bqps_pkg::DATA_W-1:0]   i_data_in,
    input  logic [bqps_pkg::POS_W-1:0]    i_position,
    input  logic [bqps_pkg::COUNT_W-1:0]  i_count,
    // output channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bqps_pkg::DATA_W-1:0]   o_data_out,
    output logic                          o_ok,
    output logic [bqps_pkg::POS_W-1:0]    o_found_position,
    output logic [bqps_pkg::COUNT_W-1:0]  o_amount_removed,
    output logic [bqps_pkg::FILL_W-1:0]   o_fill_level
);

    import bqps_pkg::*;

    // Queue bookkeeping
    t_state  r_state, n_state;
    t_ptr    r_head, n_head;
    t_ptr    r_tail, n_tail;
    t_level  r_held, n_held;

    // Pending stage: result fields waiting on the RAM read data
    logic               r_s1_valid;
    logic               r_s1_use_ram;
    logic               r_s1_ok;
    logic [POS_W-1:0]   r_s1_fpos;
    logic [COUNT_W-1:0] r_s1_removed;
    logic [FILL_W-1:0]  r_s1_fill;

    // Output register
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_ok;
    logic [POS_W-1:0]   r_out_fpos;
    logic [COUNT_W-1:0] r_out_removed;
    logic [FILL_W-1:0]  r_out_fill;

    // Search state
    logic [DATA_W-1:0]  r_key;
    t_level             r_scan_idx;
    logic               r_cmp_valid;
    t_level             r_cmp_idx;

    // RAM port
    logic               ram_we;
    t_ptr               ram_waddr;
    logic               ram_re;
    t_ptr               ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;

    // Handshake / datapath decode
    logic               accept;
    logic               s1_move;
    logic               out_take;
    logic               cmp_hit;
    logic               scan_more;
    logic               issue;
    logic               finish;
    logic               load_s1;
    logic               n_use_ram;
    logic               n_ok;
    logic [POS_W-1:0]   n_fpos;
    t_level             n_removed;
    t_level             removed;
    logic               push_ok;
    logic               pop_ok;
    logic               read_ok;
    logic               start_find;

    assign out_take = r_out_valid && i_ready;
    // pending result moves on when the output register is free or draining
    assign s1_move  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready  = (r_state == ST_IDLE) && (!r_s1_valid || s1_move);
    assign accept   = i_valid && o_ready;

    assign push_ok = (CMP_W'(r_held) < CMP_W'(CAPACITY));
    assign pop_ok  = (r_held != '0);
    assign read_ok = (CMP_W'(i_position) < CMP_W'(r_held));
    assign removed = (CMP_W'(i_count) < CMP_W'(r_held)) ? t_level'(i_count) : r_held;

    // Search: one read issued per cycle, compared against the key in the next cycle. Reads wait
    // until the pending stage has drained so its RAM data is not overwritten.
    assign cmp_hit   = r_cmp_valid && (ram_rdata == r_key);
    assign scan_more = (r_scan_idx < r_held) && !cmp_hit;
    assign issue     = (r_state == ST_SEARCH) && scan_more && !r_s1_valid;
    assign finish    = (r_state == ST_SEARCH) && (!r_s1_valid || s1_move)
                       && (cmp_hit || (!scan_more && !r_cmp_valid));

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_held     = r_held;
        ram_we     = 1'b0;
        ram_waddr  = r_tail;
        ram_re     = 1'b0;
        ram_raddr  = wrap_add(r_head, r_scan_idx);
        load_s1    = 1'b0;
        n_use_ram  = 1'b0;
        n_ok       = 1'b0;
        n_fpos     = '0;
        n_removed  = '0;
        start_find = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    load_s1 = 1'b1;
                    case (i_kind)
                        KIND_PUSH: begin
                            if (push_ok) begin
                                ram_we = 1'b1;
                                n_tail = wrap_add(r_tail, t_level'(1));
                                n_held = r_held + t_level'(1);
                                n_ok   = 1'b1;
                            end
                        end
                        KIND_POP: begin
                            if (pop_ok) begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_head    = wrap_add(r_head, t_level'(1));
                                n_held    = r_held - t_level'(1);
                                n_ok      = 1'b1;
                                n_use_ram = 1'b1;
                            end
                        end
                        KIND_DISCARD: begin
                            n_head    = wrap_add(r_head, removed);
                            n_held    = r_held - removed;
                            n_removed = removed;
                            n_ok      = (removed != '0);
                        end
                        KIND_READ: begin
                            if (read_ok) begin
                                ram_re    = 1'b1;
                                ram_raddr = wrap_add(r_head, t_level'(i_position));
                                n_ok      = 1'b1;
                                n_use_ram = 1'b1;
                            end
                        end
                        KIND_FIND: begin
                            load_s1    = 1'b0;
                            start_find = 1'b1;
                            n_state    = ST_SEARCH;
                        end
                        default: begin
                            // unused codes: no change, fill level only
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                ram_re = issue;
                if (finish) begin
                    load_s1 = 1'b1;
                    n_ok    = cmp_hit;
                    n_fpos  = cmp_hit ? POS_W'(r_cmp_idx) : '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_scan_idx  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_held <= n_held;

            if (load_s1) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end

            if (start_find) begin
                r_scan_idx  <= '0;
                r_cmp_valid <= 1'b0;
            end else begin
                r_cmp_valid <= issue;
                if (issue) begin
                    r_scan_idx <= r_scan_idx + t_level'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_s1_use_ram <= n_use_ram;
            r_s1_ok      <= n_ok;
            r_s1_fpos    <= n_fpos;
            r_s1_removed <= COUNT_W'(n_removed);
            r_s1_fill    <= FILL_W'(n_held);
        end
        if (s1_move) begin
            r_out_data    <= r_s1_use_ram ? ram_rdata : '0;
            r_out_ok      <= r_s1_ok;
            r_out_fpos    <= r_s1_fpos;
            r_out_removed <= r_s1_removed;
            r_out_fill    <= r_s1_fill;
        end
        if (start_find) begin
            r_key <= i_data_in;
        end
        if (issue) begin
            r_cmp_idx <= r_scan_idx;
        end
    end

    // A push writes its entry at the edge that takes the beat; any read of that entry is
    // issued at a later edge, so the registered-read RAM needs no bypass.
    bqps_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_in),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid          = r_out_valid;
    assign o_data_out       = r_out_data;
    assign o_ok             = r_out_ok;
    assign o_found_position = r_out_fpos;
    assign o_amount_removed = r_out_removed;
    assign o_fill_level     = r_out_fill;

endmodule

>>> hw/rtl/bqps_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module bqps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds when not enabled
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/bqps_chk.sv
// Port-level checker for the byte queue, bound to the top level.
`include "byte_queue_with_peek_and_search_top_defines.svh"

module bqps_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [bqps_pkg::DATA_W-1:0]   o_data_out,
    input logic                          o_ok,
    input logic [bqps_pkg::POS_W-1:0]    o_found_position,
    input logic [bqps_pkg::COUNT_W-1:0]  o_amount_removed,
    input logic [bqps_pkg::FILL_W-1:0]   o_fill_level
);

    import bqps_pkg::*;

    // no result beat straight out of reset
    `BQPS_ASSERT_RST(a_rst_quiet, !i_rst_n |=> !o_valid, "output valid after reset")

    // a stalled result beat holds
    `BQPS_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_fill_level) && $stable(o_data_out), "stalled result changed")

    // fill level never exceeds the capacity
    `BQPS_ASSERT(a_fill_cap, o_valid |-> o_fill_level <= CAPACITY, "fill level above capacity")

    // failed operations carry no byte and no position
    `BQPS_ASSERT(a_fail_zero, o_valid && !o_ok |-> o_data_out == 0 && o_found_position == 0, "data on failed op")

    // bytes removed only by a successful discard
    `BQPS_ASSERT(a_removed_ok, o_valid && o_amount_removed != 0 |-> o_ok, "removal without ok")

endmodule

bind byte_queue_with_peek_and_search_top bqps_chk u_bqps_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_data_out       (o_data_out),
    .o_ok             (o_ok),
    .o_found_position (o_found_position),
    .o_amount_removed (o_amount_removed),
    .o_fill_level     (o_fill_level)
);

>>> verif/tb_byte_queue_with_peek_and_search_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the byte queue: shadow queue predictor, scoreboard, test tasks.
module tb_byte_queue_with_peek_and_search_top;
    import bqps_pkg::*;

    localparam int     CLK_HALF_NS    = 4;
    localparam int     RESET_CYCLES   = 6;
    localparam int     RANDOM_BEATS   = 1450;
    localparam int     CALM_BEATS     = 150;
    localparam int     PRESSURE_BEATS = 48;
    localparam int     RX_HOLD_CYCLES = 150;
    localparam int     DRAIN_LIMIT    = 20000;   // cycles; covers a find over a full queue
    localparam int     SETTLE_CYCLES  = 12;
    localparam int     MAX_PRINTS     = 40;
    localparam longint WATCHDOG_NS    = 64'd40_000_000;
    localparam int     SOFT_FILL_CAP  = 240;     // random mix steers the fill below this

    // opcodes beyond the defined set; the block must treat them as no-ops
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic               ok;
        logic [POS_W-1:0]   found_pos;
        logic [COUNT_W-1:0] removed;
        logic [FILL_W-1:0]  fill;
    } t_queue_result;

    // ------------------------------------------------------------------
    // Clock, reset, DUT hookup
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [KIND_W-1:0]  in_kind     = '0;
    logic [DATA_W-1:0]  in_data     = '0;
    logic [POS_W-1:0]   in_position = '0;
    logic [COUNT_W-1:0] in_count    = '0;

    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [DATA_W-1:0]  out_data;
    logic               out_ok;
    logic [POS_W-1:0]   out_found_pos;
    logic [COUNT_W-1:0] out_removed;
    logic [FILL_W-1:0]  out_fill;

    always begin
        #(CLK_HALF_NS) clk = 1'b1;
        #(CLK_HALF_NS) clk = 1'b0;
    end

    byte_queue_with_peek_and_search_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_kind           (in_kind),
        .i_data_in        (in_data),
        .i_position       (in_position),
        .i_count          (in_count),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_data_out       (out_data),
        .o_ok             (out_ok),
        .o_found_position (out_found_pos),
        .o_amount_removed (out_removed),
        .o_fill_level     (out_fill)
    );

    // ------------------------------------------------------------------
    // Shadow queue: the expected contents of the byte store
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] shadow_bytes [CAPACITY];
    int unsigned       shadow_head = 0;
    int unsigned       shadow_tail = 0;
    int unsigned       shadow_held = 0;

    t_queue_result     pending_results[$];

    // run statistics for the closing summary
    int beats_sent     = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int refused_pushes = 0;
    int find_hits      = 0;
    int find_misses    = 0;
    int peak_fill      = 0;

    logic idle_on = 1'b0;   // random idle bursts on both sides
    logic rx_hold = 1'b0;   // long receiver hold-off in progress
    event rx_hold_kick;

    // Apply one operation to the shadow queue and return the result it must produce.
    function automatic t_queue_result queue_apply_op(input logic [KIND_W-1:0] kind,
                                                     input logic [DATA_W-1:0] value,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [COUNT_W-1:0] cnt);
        t_queue_result r;
        int unsigned   n;
        r = '0;
        case (kind)
            KIND_PUSH: begin
                if (shadow_held < CAPACITY) begin
                    shadow_bytes[shadow_tail] = value;
                    shadow_tail = (shadow_tail + 1) % CAPACITY;
                    shadow_held++;
                    r.ok = 1'b1;
                end else begin
                    refused_pushes++;
                end
            end
            KIND_POP: begin
                if (shadow_held > 0) begin
                    r.data = shadow_bytes[shadow_head];
                    shadow_head = (shadow_head + 1) % CAPACITY;
                    shadow_held--;
                    r.ok = 1'b1;
                end
            end
            KIND_DISCARD: begin
                n = (cnt < shadow_held) ? cnt : shadow_held;
                shadow_head = (shadow_head + n) % CAPACITY;
                shadow_held -= n;
                r.removed = COUNT_W'(n);
                r.ok = (n > 0);
            end
            KIND_READ: begin
                if (pos < shadow_held) begin
                    r.data = shadow_bytes[(shadow_head + pos) % CAPACITY];
                    r.ok = 1'b1;
                end
            end
            KIND_FIND: begin
                // first match from the head wins
                for (n = 0; n < shadow_held && !r.ok; n++) begin
                    if (shadow_bytes[(shadow_head + n) % CAPACITY] == value) begin
                        r.ok = 1'b1;
                        r.found_pos = POS_W'(n);
                    end
                end
                if (r.ok) find_hits++;
                else find_misses++;
            end
            default: begin
            end
        endcase
        r.fill = FILL_W'(shadow_held);
        if (shadow_held > peak_fill) peak_fill = shadow_held;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand_byte();
        return DATA_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        return POS_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [COUNT_W-1:0] rand_count();
        return COUNT_W'($urandom_range(0, 4096));
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < MAX_PRINTS) begin
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Input side: one beat, with an optional idle burst in front of it.
    // Valid stays high from beat to beat unless a gap is taken, so it never
    // sees two writes in one time step.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value,
                             input logic [POS_W-1:0] pos, input logic [COUNT_W-1:0] cnt);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_kind     <= kind;
        in_data     <= value;
        in_position <= pos;
        in_count    <= cnt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // beat taken at this edge: predict right away
        pending_results.push_back(queue_apply_op(kind, value, pos, cnt));
        beats_sent++;
    endtask

    // Sender pauses until every outstanding result has come back or the drain limit runs out.
    task automatic wait_for_all_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall bursts, plus a long hold-off timed by its own
    // process below.
    // ------------------------------------------------------------------
    int rx_gap_left = 0;

    always @(posedge clk) begin
        if (rx_hold) begin
            out_ready <= 1'b0;
        end else if (rx_gap_left != 0) begin
            out_ready   <= 1'b0;
            rx_gap_left <= rx_gap_left - 1;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            out_ready   <= 1'b0;
            rx_gap_left <= $urandom_range(0, 7);
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin : rx_hold_timer
        forever begin
            @(rx_hold_kick);
            rx_hold <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: every result beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_queue_result want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing expected, fill", out_fill, 0);
            end else begin
                want = pending_results.pop_front();
                if (out_data !== want.data)
                    report_mismatch("data_out", out_data, want.data);
                if (out_ok !== want.ok)
                    report_mismatch("ok", out_ok, want.ok);
                if (out_found_pos !== want.found_pos)
                    report_mismatch("found_position", out_found_pos, want.found_pos);
                if (out_removed !== want.removed)
                    report_mismatch("amount_removed", out_removed, want.removed);
                if (out_fill !== want.fill)
                    report_mismatch("fill_level", out_fill, want.fill);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic apply_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n   <= 1'b1;
        idle_on <= 1'b1;
        @(posedge clk);
    endtask

    // Empty-queue corner cases, a few bytes at the value extremes, every defined opcode and two spare codes.
    task automatic test_empty_and_basic();
        send_beat(KIND_POP, rand_byte(), rand_pos(), rand_count());      // pop when empty
        send_beat(KIND_READ, rand_byte(), '0, rand_count());             // read past fill
        send_beat(KIND_FIND, 8'h00, rand_pos(), rand_count());           // find, nothing held
        send_beat(KIND_DISCARD, rand_byte(), rand_pos(), '0);
        send_beat(KIND_DISCARD, rand_byte(), rand_pos(), 13'd4096);
        send_beat(KIND_PUSH, 8'h00, rand_pos(), rand_count());
        send_beat(KIND_PUSH, 8'hFF, rand_pos(), rand_count());
        send_beat(KIND_PUSH, 8'hA5, rand_pos(), rand_count());
        send_beat(KIND_PUSH, 8'h5A, rand_pos(), rand_count());
        send_beat(KIND_READ, rand_byte(), 12'd0, rand_count());
        send_beat(KIND_READ, rand_byte(), 12'd3, rand_count());
        send_beat(KIND_READ, rand_byte(), 12'd4, rand_count());          // one past the tail
        send_beat(KIND_READ, rand_byte(), 12'd4095, rand_count());
        send_beat(KIND_FIND, 8'hFF, rand_pos(), rand_count());
        send_beat(KIND_FIND, 8'h5A, rand_pos(), rand_count());
        send_beat(KIND_FIND, 8'h11, rand_pos(), rand_count());           // no match
        send_beat(KIND_SPARE_LO, rand_byte(), rand_pos(), rand_count());
        send_beat(KIND_SPARE_HI, rand_byte(), rand_pos(), rand_count());
        send_beat(KIND_POP, rand_byte(), rand_pos(), rand_count());
        send_beat(KIND_DISCARD, rand_byte(), rand_pos(), '0);            // count zero
        send_beat(KIND_DISCARD, rand_byte(), rand_pos(), 13'd1);
        send_beat(KIND_DISCARD, rand_byte(), rand_pos(), 13'd4096);      // more than held
        send_beat(KIND_POP, rand_byte(), rand_pos(), rand_count());
    endtask

    // One random operation, weighted toward well-formed traffic on the held bytes.
    task automatic send_random_op();
        int                push_weight;
        int                roll;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  pos;
        logic [COUNT_W-1:0] cnt;
        push_weight = (shadow_held > SOFT_FILL_CAP) ? 15 : 38;
        roll  = $urandom_range(0, push_weight + 62);
        value = rand_byte();
        pos   = rand_pos();
        cnt   = rand_count();
        if (roll < push_weight) begin
            send_beat(KIND_PUSH, value, pos, cnt);
        end else if (roll < push_weight + 15) begin
            send_beat(KIND_POP, value, pos, cnt);
        end else if (roll < push_weight + 25) begin
            case ($urandom_range(0, 9))
                0:       cnt = rand_count();
                1, 2:    cnt = COUNT_W'($urandom_range(0, shadow_held + 4));
                default: cnt = COUNT_W'($urandom_range(0, 6));
            endcase
            send_beat(KIND_DISCARD, value, pos, cnt);
        end else if (roll < push_weight + 45) begin
            // mostly inside the held range or just past it
            if ($urandom_range(0, 9) < 7) pos = POS_W'($urandom_range(0, shadow_held));
            send_beat(KIND_READ, value, pos, cnt);
        end else if (roll < push_weight + 60) begin
            if (shadow_held > 0 && $urandom_range(0, 9) < 7)
                value = shadow_bytes[(shadow_head + $urandom_range(0, shadow_held - 1))
                                     % CAPACITY];
            send_beat(KIND_FIND, value, pos, cnt);
        end else begin
            send_beat(KIND_W'($urandom_range(int'(KIND_SPARE_LO), int'(KIND_SPARE_HI))),
                      value, pos, cnt);
        end
    endtask

    task automatic test_random_mix(input int beats, input bit vary_idling);
        int k;
        for (k = 0; k < beats; k++) begin
            // a calm stretch in the middle of the varied run
            if (vary_idling && k == beats / 3) idle_on <= 1'b0;
            if (vary_idling && k == 2 * beats / 3) idle_on <= 1'b1;
            send_random_op();
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps pushing, with a read
    // every sixth beat, so the block backs up and drops o_ready; then the sender waits it out.
    task automatic test_output_backpressure();
        int k;
        -> rx_hold_kick;
        for (k = 0; k < PRESSURE_BEATS; k++) begin
            if (k % 6 == 5) send_beat(KIND_READ, rand_byte(), POS_W'(k), rand_count());
            else send_beat(KIND_PUSH, rand_byte(), rand_pos(), rand_count());
        end
        wait_for_all_results();
    endtask

    task automatic finish_run();
        wait_for_all_results();
        if (pending_results.size() != 0) begin
            $display("timed out with %0d results outstanding", pending_results.size());
            $display("** byte_queue_with_peek_and_search_top: FAILED **");
            $finish;
        end else begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            $display("%0d beats sent, %0d results checked, %0d mismatches",
                     beats_sent, results_seen, mismatch_count);
            $display("peak fill %0d of %0d, %0d pushes refused, finds %0d hit / %0d missed",
                     peak_fill, CAPACITY, refused_pushes, find_hits, find_misses);
            if (mismatch_count == 0 && pending_results.size() == 0) begin
                $display("** byte_queue_with_peek_and_search_top: PASSED **");
            end else begin
                $display("** byte_queue_with_peek_and_search_top: FAILED **");
            end
            $finish;
        end
    endtask

    initial begin
        apply_reset();
        test_empty_and_basic();
        test_random_mix(RANDOM_BEATS, 1'b1);
        test_output_backpressure();
        // last part of the run: no idling on either side
        idle_on <= 1'b0;
        test_random_mix(CALM_BEATS, 1'b0);
        finish_run();
    end

    // Watchdog for a hung handshake.
    initial begin
        #(WATCHDOG_NS);
        $display("watchdog expired after %0d beats sent", beats_sent);
        $display("** byte_queue_with_peek_and_search_top: FAILED **");
        $finish;
    end

endmodule
